// File: hw/rtl/sts_pkg.sv
// Package: shared types, constants and word formats of the tensor smoothing block.
`timescale 1ns / 1ps
`default_nettype none
package sts_pkg;
	localparam int COMPONENTS_DEF = 6;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int ACC_WIDTH_DEF  = 64;
	localparam int MIN_DEN_W      = 31;
	localparam logic [MIN_DEN_W-1:0] MIN_DEN_RESET = 31'd1;

	typedef struct packed {
		logic [2:0]         own_type;
		logic [2:0]         nbr_type;
		logic [30:0]        nbr_mass;
		logic [30:0]        nbr_density;
		logic signed [31:0] kernel_weight;
		logic signed [31:0] comp_0;
		logic signed [31:0] comp_1;
		logic signed [31:0] comp_2;
		logic signed [31:0] comp_3;
		logic signed [31:0] comp_4;
		logic signed [31:0] comp_5;
		logic               last_neighbour;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] avg_0;
		logic signed [31:0] avg_1;
		logic signed [31:0] avg_2;
		logic signed [31:0] avg_3;
		logic signed [31:0] avg_4;
		logic signed [31:0] avg_5;
		logic               updated;
	} out_word_t;

	// Classified word handed from the front to the back through the queue.
	typedef struct packed {
		logic                         match;
		logic                         last;
		logic [30:0]                  mass;
		logic [30:0]                  density;
		logic signed [31:0]           weight;
		logic [COMPONENTS_DEF*32-1:0] comps;
	} job_t;
endpackage
`default_nettype wire

// File: hw/rtl/sts_front.sv
// Front end: accepts neighbour words, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module sts_front
	import sts_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire in_word_t in_data,
	input  wire logic     in_valid,
	output logic          in_ready,
	output job_t          job,
	output logic          job_valid,
	input  wire logic     job_ready
);
	job_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	job_t       j;

	assign in_ready  = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = mem_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;

	always_comb begin
		j.match   = (in_data.own_type == in_data.nbr_type);
		j.last    = in_data.last_neighbour;
		j.mass    = in_data.nbr_mass;
		j.density = in_data.nbr_density;
		j.weight  = in_data.kernel_weight;
		j.comps   = {in_data.comp_5, in_data.comp_4, in_data.comp_3,
			in_data.comp_2, in_data.comp_1, in_data.comp_0};
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= j;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/sts_back.sv
// Back end: sequencer that computes volume, accumulates terms and divides at the end.
`timescale 1ns / 1ps
`default_nettype none
module sts_back
	import sts_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [MIN_DEN_W-1:0] min_den,
	input  wire job_t                 job,
	input  wire logic                 job_valid,
	output logic                      job_ready,
	output out_word_t                 out_data,
	output logic                      out_valid,
	input  wire logic                 out_ready
);
	localparam int NC = COMPONENTS_DEF;
	localparam int VN = 31 + FRAC_BITS;
	localparam int VC = $clog2(VN + 1);
	localparam int QC = $clog2(ACC_WIDTH + FRAC_BITS + 1);
	localparam int KC = $clog2(NC + 1);
	localparam logic signed [ACC_WIDTH-1:0] AMAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [ACC_WIDTH-1:0] AMIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001, S_VDIV = 7'b0000010, S_VW = 7'b0000100,
		S_TERM = 7'b0001000, S_FIN = 7'b0010000, S_DIV = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	state_t                  state_q;
	job_t                    job_q;
	logic [VN-1:0]           vq_q;
	logic [31:0]             vr_q;
	logic [VC-1:0]           vcnt_q;
	logic signed [31:0]      vw_q;
	logic signed [ACC_WIDTH-1:0] sum_q [NC];
	logic signed [ACC_WIDTH-1:0] wsum_q;
	logic [KC-1:0]           k_q;
	logic [ACC_WIDTH+FRAC_BITS-1:0] dq_q;
	logic [ACC_WIDTH:0]      dr_q;
	logic [ACC_WIDTH-1:0]    dd_q;
	logic [QC-1:0]           dcnt_q;
	logic                    neg_q;
	logic [31:0]             avg_q [NC];
	logic                    upd_q;

	logic [31:0]             vr_sh;
	logic [VN-1:0]           vnum;
	logic                    vge;
	logic signed [63:0]      vw_prod;
	logic signed [63:0]      vw_fl;
	logic signed [63:0]      t_prod;
	logic signed [ACC_WIDTH:0] t_add, w_add;
	logic [ACC_WIDTH:0]      dr_sh;
	logic [ACC_WIDTH-1:0]    nmag, wmag;
	logic [ACC_WIDTH+FRAC_BITS-1:0] qv;
	logic [31:0]             mag;

	function automatic logic signed [ACC_WIDTH-1:0] sat_acc(input logic signed [ACC_WIDTH:0] x);
		if (x > $signed({AMAX[ACC_WIDTH-1], AMAX})) return AMAX;
		if (x < $signed({AMIN[ACC_WIDTH-1], AMIN})) return AMIN;
		return x[ACC_WIDTH-1:0];
	endfunction

	assign vnum    = {job_q.mass, {FRAC_BITS{1'b0}}};
	assign vr_sh   = {vr_q[30:0], vnum[VN-1-32'(vcnt_q)]};
	assign vge     = ({1'b0, vr_sh} >= {2'b0, job_q.density});
	assign vw_prod = $signed({1'b0, vq_q[30:0]}) * 64'(job_q.weight);
	assign vw_fl   = vw_prod >>> FRAC_BITS;
	assign t_prod  = 64'(vw_q) * 64'($signed(job_q.comps[32*k_q +: 32]));
	assign t_add   = (ACC_WIDTH+1)'(sum_q[k_q]) + (ACC_WIDTH+1)'(t_prod >>> FRAC_BITS);
	assign w_add   = (ACC_WIDTH+1)'(wsum_q) + (ACC_WIDTH+1)'(vw_q);
	assign nmag    = sum_q[0][ACC_WIDTH-1] ? -sum_q[0] : sum_q[0];
	assign wmag    = wsum_q[ACC_WIDTH-1] ? -wsum_q : wsum_q;
	assign dr_sh   = {dr_q[ACC_WIDTH-1:0], dq_q[ACC_WIDTH+FRAC_BITS-1]};
	assign qv      = dq_q;
	always_comb begin
		if (qv[ACC_WIDTH+FRAC_BITS-1:31] != '0) mag = 32'h8000_0000;
		else mag = qv[31:0];
	end

	assign job_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data  = '{avg_0: avg_q[0], avg_1: avg_q[1], avg_2: avg_q[2],
		avg_3: avg_q[3], avg_4: avg_q[4], avg_5: avg_q[5], updated: upd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q <= '0; vq_q <= '0; vr_q <= '0; vcnt_q <= '0; vw_q <= '0;
			wsum_q <= '0; k_q <= '0; dq_q <= '0; dr_q <= '0; dd_q <= '0;
			dcnt_q <= '0; neg_q <= 1'b0; upd_q <= 1'b0;
			for (int i = 0; i < NC; i++) begin
				sum_q[i] <= '0;
				avg_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					job_q <= job; vq_q <= '0; vr_q <= '0; vcnt_q <= '0; k_q <= '0;
				end
				S_VDIV: begin
					if (vge) vr_q <= vr_sh - {1'b0, job_q.density};
					else vr_q <= vr_sh;
					if (vcnt_q == VC'(VN - 1) && vq_q[VN-2:30] != '0)
						vq_q <= VN'(31'h7FFF_FFFF);
					else vq_q <= {vq_q[VN-2:0], vge};
					vcnt_q <= vcnt_q + 1'b1;
				end
				S_VW: begin
					if (vw_fl > 64'sd2147483647) vw_q <= 32'h7FFF_FFFF;
					else if (vw_fl < -64'sd2147483648) vw_q <= 32'h8000_0000;
					else vw_q <= vw_fl[31:0];
				end
				S_TERM: begin
					sum_q[k_q] <= sat_acc(t_add);
					k_q <= k_q + 1'b1;
					if (k_q == KC'(NC - 1)) wsum_q <= sat_acc(w_add);
				end
				S_FIN: begin
					k_q <= '0;
					dq_q <= {nmag, {FRAC_BITS{1'b0}}};
					dr_q <= '0; dd_q <= wmag; dcnt_q <= '0;
					neg_q <= sum_q[0][ACC_WIDTH-1] ^ wsum_q[ACC_WIDTH-1];
					upd_q <= ({1'b0, wmag} > (ACC_WIDTH+1)'(min_den));
				end
				S_DIV: begin
					if (dcnt_q != QC'(ACC_WIDTH + FRAC_BITS)) begin
						if (dr_sh >= {1'b0, dd_q}) begin
							dr_q <= dr_sh - {1'b0, dd_q}; dq_q <= {dq_q[ACC_WIDTH+FRAC_BITS-2:0], 1'b1};
						end else begin
							dr_q <= dr_sh; dq_q <= {dq_q[ACC_WIDTH+FRAC_BITS-2:0], 1'b0};
						end
						dcnt_q <= dcnt_q + 1'b1;
					end else begin
						if (!upd_q) avg_q[k_q] <= '0;
						else if (neg_q) avg_q[k_q] <= -mag;
						else avg_q[k_q] <= mag[31] ? 32'h7FFF_FFFF : mag;
						if (k_q != KC'(NC - 1)) begin
							dq_q <= {(sum_q[k_q+1'b1][ACC_WIDTH-1] ? -sum_q[k_q+1'b1] : sum_q[k_q+1'b1]),
								{FRAC_BITS{1'b0}}};
							neg_q <= sum_q[k_q+1'b1][ACC_WIDTH-1] ^ wsum_q[ACC_WIDTH-1];
						end
						dr_q <= '0; dcnt_q <= '0;
						k_q <= k_q + 1'b1;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						for (int i = 0; i < NC; i++) sum_q[i] <= '0;
						wsum_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (job_valid) state_q <= job.match ? S_VDIV : (job.last ? S_FIN : S_IDLE);
				S_VDIV: if (vcnt_q == VC'(VN - 1)) state_q <= S_VW;
				S_VW: state_q <= S_TERM;
				S_TERM: if (k_q == KC'(NC - 1)) state_q <= job_q.last ? S_FIN : S_IDLE;
				S_FIN: state_q <= S_DIV;
				S_DIV: if (dcnt_q == QC'(ACC_WIDTH + FRAC_BITS) && k_q == KC'(NC - 1))
					state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: hw/rtl/shepard_tensor_smoothing.sv
// Top level of the Shepard tensor smoothing block.
// channel | signals                        | word
// in      | in_data, in_valid, in_ready    | one neighbour
// out     | out_data, out_valid, out_ready | one smoothed tensor
// cfg     | cfg_we, cfg_wdata              | min_denominator
// A matched neighbour passes through the back end in order: it leaves the queue,
// runs through the bit-serial volume divider, then the weight and the six terms.
// A mismatched one skips the volume and term steps.
// The last word adds one setup step and six serial divisions, one per component.
// Reset clears the sums and sets the threshold to one.
// A two-word queue lets the front accept while the back works or stalls.
`timescale 1ns / 1ps
`default_nettype none
module shepard_tensor_smoothing
	import sts_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire in_word_t             in_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	output out_word_t                 out_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	input  wire logic                 cfg_we,
	input  wire logic [MIN_DEN_W-1:0] cfg_wdata
);
	logic [MIN_DEN_W-1:0] min_den_q;
	job_t job;
	logic job_valid, job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_den_q <= MIN_DEN_RESET;
		else if (cfg_we) min_den_q <= cfg_wdata;
	end

	sts_front u_front (.clk, .arst_n, .in_data, .in_valid, .in_ready,
		.job, .job_valid, .job_ready);

	sts_back #(.FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_back (.clk, .arst_n,
		.min_den(min_den_q), .job, .job_valid, .job_ready, .out_data, .out_valid,
		.out_ready);
endmodule
`default_nettype wire
